@@ rtl/pcop_pkg.sv @@
// Shared constants, types and the trigonometric table builder for the polar circle block.
`default_nettype none

package pcop_pkg;

  // Default build parameters.
  localparam int ANGLE_STEPS_DEF    = 79;
  localparam int TRIG_FRAC_BITS_DEF = 16;

  // Fixed field widths.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;
  localparam int RADIUS_W  = 11;
  localparam int OFS_W     = 12;
  localparam int PIX_W     = 14;
  localparam int COLOR_W   = 4;
  localparam int OCT_W     = 3;
  localparam int STEP_W    = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd5;

  // Register reset values.
  localparam logic [11:0]         CENTER_X_RST  = 12'd0;
  localparam logic [11:0]         CENTER_Y_RST  = 12'd0;
  localparam logic [RADIUS_W-1:0] RADIUS_RST    = 11'd0;
  localparam logic [COLOR_W-1:0]  PEN_COLOR_RST = 4'd15;
  localparam logic [11:0]         ORIGIN_X_RST  = 12'd320;
  localparam logic [11:0]         ORIGIN_Y_RST  = 12'd240;

  // Emission order of the eight symmetric points.
  localparam logic [OCT_W-1:0] OCT_DX_DY   = 3'd0;
  localparam logic [OCT_W-1:0] OCT_DY_DX   = 3'd1;
  localparam logic [OCT_W-1:0] OCT_DY_NDX  = 3'd2;
  localparam logic [OCT_W-1:0] OCT_NDX_DY  = 3'd3;
  localparam logic [OCT_W-1:0] OCT_NDX_NDY = 3'd4;
  localparam logic [OCT_W-1:0] OCT_NDY_NDX = 3'd5;
  localparam logic [OCT_W-1:0] OCT_NDY_DX  = 3'd6;
  localparam logic [OCT_W-1:0] OCT_DX_NDY  = 3'd7;

  // One angle step ready for the octant serialiser.
  typedef struct packed {
    logic [OFS_W-1:0]   dx;
    logic [OFS_W-1:0]   dy;
    logic [PIX_W-1:0]   base_x;
    logic [PIX_W-1:0]   base_y;
    logic [COLOR_W-1:0] color;
  } span_t;

  // Cosine (odd clear) or sine (odd set) of 0.01*k from a thirteen-term series in Q30,
  // rounded half up to frac fractional bits. Evaluated only at elaboration.
  function automatic logic [63:0] trig_rom_value(input int unsigned k, input logic odd,
                                                 input int unsigned frac);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        tm;
    logic [63:0]        j;
    logic signed [63:0] sum;
    x   = ((64'(k) << 30) + 64'd50) / 64'd100;
    x2  = (x * x) >> 30;
    t   = odd ? x : (64'd1 << 30);
    j   = odd ? 64'd2 : 64'd1;
    sum = $signed(t);
    for (int n = 1; n <= 12; n++) begin
      tm = (t * x2) >> 30;
      // Each term is divided by j*(j+1), with j stepping by two from 1 or 2.
      case (j)
        64'd1:   t = tm / 64'd2;
        64'd2:   t = tm / 64'd6;
        64'd3:   t = tm / 64'd12;
        64'd4:   t = tm / 64'd20;
        64'd5:   t = tm / 64'd30;
        64'd6:   t = tm / 64'd42;
        64'd7:   t = tm / 64'd56;
        64'd8:   t = tm / 64'd72;
        64'd9:   t = tm / 64'd90;
        64'd10:  t = tm / 64'd110;
        64'd11:  t = tm / 64'd132;
        64'd12:  t = tm / 64'd156;
        64'd13:  t = tm / 64'd182;
        64'd14:  t = tm / 64'd210;
        64'd15:  t = tm / 64'd240;
        64'd16:  t = tm / 64'd272;
        64'd17:  t = tm / 64'd306;
        64'd18:  t = tm / 64'd342;
        64'd19:  t = tm / 64'd380;
        64'd20:  t = tm / 64'd420;
        64'd21:  t = tm / 64'd462;
        64'd22:  t = tm / 64'd506;
        64'd23:  t = tm / 64'd552;
        64'd24:  t = tm / 64'd600;
        default: t = '0;
      endcase
      j = j + 64'd2;
      if ((n % 2) == 1) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return (64'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage

`default_nettype wire

@@ rtl/polar_circle_octant_points.sv @@
// Top level of the polar circle block: eight symmetric circle points per angle step.
//
//   Channel   Direction  Handshake             Payload
//   request   in         in_valid / in_stall   angle_step
//   point     out        out_valid / out_stall pixel_x, pixel_y, pixel_color, octant, last_point
//   config    in         cfg_we                cfg_index, cfg_data
//
// Each accepted request in range yields eight points, one per cycle while out_stall is low;
// the octant serialiser holds one request and takes the next as its eighth point leaves.
// A request passes the address register, table read, multiply, rounding, serialiser load
// and output register before its first point appears.
// A request whose angle step is ANGLE_STEPS or more is accepted and gives no points.
// Reset is synchronous and active high; it empties the pipeline and restores the
// register defaults. Stalls on the point channel back up stage by stage; nothing is
// lost or repeated, and requests keep being taken while any stage has room.
`default_nettype none

module polar_circle_octant_points #(
  parameter int ANGLE_STEPS    = pcop_pkg::ANGLE_STEPS_DEF,
  parameter int TRIG_FRAC_BITS = pcop_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pcop_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pcop_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pcop_pkg::STEP_W-1:0]       angle_step,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [pcop_pkg::PIX_W-1:0]      pixel_x,
  output logic signed [pcop_pkg::PIX_W-1:0]      pixel_y,
  output logic        [pcop_pkg::COLOR_W-1:0]    pixel_color,
  output logic        [pcop_pkg::OCT_W-1:0]      octant,
  output logic                                   last_point
);

  localparam int ROM_W  = TRIG_FRAC_BITS + 1;
  localparam int ROM_AW = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
  localparam int PROD_W = ROM_W + pcop_pkg::RADIUS_W;

  typedef logic [ROM_W-1:0] rom_t [ANGLE_STEPS];

  // The cosine and sine tables are worked out at elaboration.
  function automatic rom_t build_rom(input logic odd);
    rom_t tbl;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      tbl[k] = ROM_W'(pcop_pkg::trig_rom_value(k, odd, TRIG_FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam rom_t COS_ROM = build_rom(1'b0);
  localparam rom_t SIN_ROM = build_rom(1'b1);

  // Configuration registers.
  logic [11:0]                     center_x;
  logic [11:0]                     center_y;
  logic [pcop_pkg::RADIUS_W-1:0]   radius;
  logic [pcop_pkg::COLOR_W-1:0]    pen_color;
  logic [11:0]                     origin_x;
  logic [11:0]                     origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= pcop_pkg::CENTER_X_RST;
      center_y  <= pcop_pkg::CENTER_Y_RST;
      radius    <= pcop_pkg::RADIUS_RST;
      pen_color <= pcop_pkg::PEN_COLOR_RST;
      origin_x  <= pcop_pkg::ORIGIN_X_RST;
      origin_y  <= pcop_pkg::ORIGIN_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcop_pkg::REG_CENTER_X:  center_x  <= cfg_data;
        pcop_pkg::REG_CENTER_Y:  center_y  <= cfg_data;
        pcop_pkg::REG_RADIUS:    radius    <= cfg_data[pcop_pkg::RADIUS_W-1:0];
        pcop_pkg::REG_PEN_COLOR: pen_color <= cfg_data[pcop_pkg::COLOR_W-1:0];
        pcop_pkg::REG_ORIGIN_X:  origin_x  <= cfg_data;
        pcop_pkg::REG_ORIGIN_Y:  origin_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and per-stage room.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic take;
  logic in_range;

  assign rdy4     = !v4 || take;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign in_range = ({25'd0, angle_step} < 32'(ANGLE_STEPS));

  // Stage payloads.
  logic [ROM_AW-1:0]     addr;
  logic [ROM_W-1:0]      cos_q;
  logic [ROM_W-1:0]      sin_q;
  logic [PROD_W-1:0]     prod_c;
  logic [PROD_W-1:0]     prod_s;
  logic [PROD_W:0]       rnd_c;
  logic [PROD_W:0]       rnd_s;
  pcop_pkg::span_t       span;

  // Rounding half up back to whole pixels.
  assign rnd_c = {1'b0, prod_c} + ((PROD_W + 1)'(1) << (TRIG_FRAC_BITS - 1));
  assign rnd_s = {1'b0, prod_s} + ((PROD_W + 1)'(1) << (TRIG_FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid && in_range;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: register the table address; out-of-range steps never become valid.
    if (rdy1 && in_valid && in_range) begin
      addr <= ROM_AW'(angle_step);
    end
    // Stage 2: cosine and sine table read.
    if (rdy2 && v1) begin
      cos_q <= COS_ROM[addr];
      sin_q <= SIN_ROM[addr];
    end
    // Stage 3: scale by the radius.
    if (rdy3 && v2) begin
      prod_c <= PROD_W'(radius) * PROD_W'(cos_q);
      prod_s <= PROD_W'(radius) * PROD_W'(sin_q);
    end
    // Stage 4: round the offsets and fold the centre into the screen origin.
    if (rdy4 && v3) begin
      span.dx     <= rnd_c[TRIG_FRAC_BITS +: pcop_pkg::OFS_W];
      span.dy     <= rnd_s[TRIG_FRAC_BITS +: pcop_pkg::OFS_W];
      span.base_x <= {2'b00, origin_x} + {{2{center_x[11]}}, center_x};
      span.base_y <= {2'b00, origin_y} - {{2{center_y[11]}}, center_y};
      span.color  <= pen_color;
    end
  end

  pcop_octant_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .span_valid  (v4),
    .span        (span),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .octant      (octant),
    .last_point  (last_point)
  );

endmodule

`default_nettype wire

@@ rtl/pcop_octant_ser.sv @@
// Octant serialiser: turns one angle step into eight registered screen points.
`default_nettype none

module pcop_octant_ser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           span_valid,
  input  wire pcop_pkg::span_t                span,
  output logic                                take,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [pcop_pkg::PIX_W-1:0]   pixel_x,
  output logic signed [pcop_pkg::PIX_W-1:0]   pixel_y,
  output logic        [pcop_pkg::COLOR_W-1:0] pixel_color,
  output logic        [pcop_pkg::OCT_W-1:0]   octant,
  output logic                                last_point
);

  pcop_pkg::span_t                  held;
  logic                             held_valid;
  logic [pcop_pkg::OCT_W-1:0]       oct;
  logic                             adv;
  logic [pcop_pkg::PIX_W-1:0]       dx_w;
  logic [pcop_pkg::PIX_W-1:0]       dy_w;
  logic [pcop_pkg::PIX_W-1:0]       ox;
  logic [pcop_pkg::PIX_W-1:0]       oy;

  // A point moves out whenever the output register is free or being emptied.
  assign adv  = held_valid && (!out_valid || !out_stall);
  assign take = !held_valid || (adv && (oct == pcop_pkg::OCT_DX_NDY));

  assign dx_w = {{(pcop_pkg::PIX_W - pcop_pkg::OFS_W){1'b0}}, held.dx};
  assign dy_w = {{(pcop_pkg::PIX_W - pcop_pkg::OFS_W){1'b0}}, held.dy};

  always_comb begin
    case (oct)
      pcop_pkg::OCT_DX_DY:   begin ox = dx_w;  oy = dy_w;  end
      pcop_pkg::OCT_DY_DX:   begin ox = dy_w;  oy = dx_w;  end
      pcop_pkg::OCT_DY_NDX:  begin ox = dy_w;  oy = -dx_w; end
      pcop_pkg::OCT_NDX_DY:  begin ox = -dx_w; oy = dy_w;  end
      pcop_pkg::OCT_NDX_NDY: begin ox = -dx_w; oy = -dy_w; end
      pcop_pkg::OCT_NDY_NDX: begin ox = -dy_w; oy = -dx_w; end
      pcop_pkg::OCT_NDY_DX:  begin ox = -dy_w; oy = dx_w;  end
      pcop_pkg::OCT_DX_NDY:  begin ox = dx_w;  oy = -dy_w; end
      default:               begin ox = dx_w;  oy = dy_w;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      oct        <= pcop_pkg::OCT_DX_DY;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        held_valid <= span_valid;
      end
      if (adv) begin
        oct       <= oct + 3'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && span_valid) begin
      held <= span;
    end
    if (adv) begin
      pixel_x     <= held.base_x + ox;
      pixel_y     <= held.base_y - oy;
      pixel_color <= held.color;
      octant      <= oct;
      last_point  <= (oct == pcop_pkg::OCT_DX_NDY);
    end
  end

endmodule

`default_nettype wire

@@ rtl/pcop_port_check.sv @@
// Port-level checks for the polar circle block, bound to its top level.
`default_nettype none

module pcop_port_check (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [pcop_pkg::PIX_W-1:0] pixel_x,
  input wire logic signed [pcop_pkg::PIX_W-1:0] pixel_y,
  input wire logic [pcop_pkg::COLOR_W-1:0]      pixel_color,
  input wire logic [pcop_pkg::OCT_W-1:0]        octant,
  input wire logic                              last_point
);

  // A stalled point holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(octant) && $stable(last_point))
    else $error("stalled point changed");

  // The last flag marks the eighth point only.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_point == (octant == pcop_pkg::OCT_DX_NDY)))
    else $error("last_point does not match octant");

  // Points of one request follow back to back in octant order with one colour.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (octant != pcop_pkg::OCT_DX_NDY) |=>
      out_valid && (octant == $past(octant) + 3'd1) && (pixel_color == $past(pixel_color)))
    else $error("octant sequence broken");

  // Reset leaves the block empty and ready.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind polar_circle_octant_points pcop_port_check u_port_check (.*);

`default_nettype wire
